>>> hw/rtl/postfix_stack_evaluator_macros.svh
// assertion macros for the postfix stack evaluator
// depends on nothing; included by the files that assert
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH

// condition holds at every clock edge outside reset
`define PSE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define PSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/pse_pkg.sv
// types and constants of the postfix stack evaluator
// depends on nothing; used by the result interface, the top level and the testbench
package pse_pkg;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_IGNORED   = 3'd1,
		STAT_UNDERFLOW = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_DIVZERO   = 3'd4,
		STAT_SAT       = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_DIVFIN,
		S_WRITE,
		S_DONE
	} state_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

endpackage

>>> hw/rtl/pse_if.sv
// valid/ready channel interfaces of the postfix stack evaluator
// character channel in, result channel out; depends on pse_pkg
interface pse_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       start_req;

	modport source (output valid, output char_code, output start_req, input ready);
	modport sink   (input valid, input char_code, input start_req, output ready);
endinterface

interface pse_result_if;
	import pse_pkg::*;
	logic               valid;
	logic               ready;
	logic signed [31:0] top_value;
	logic [4:0]         stack_depth;
	status_t            status;

	modport source (output valid, output top_value, output stack_depth, output status,
		input ready);
	modport sink   (input valid, input top_value, input stack_depth, input status,
		output ready);
endinterface

>>> hw/rtl/postfix_stack_evaluator.sv
// postfix stack evaluator top level: sequencer, operand memory, shared adder,
// multiplier and bit-serial divider; depends on pse_pkg, pse_if and the macro header
//
// usage
//  chars:  one ASCII character per transaction; start_req empties the stack first.
//          a digit pushes d * 2^FRAC_BITS, + - * / pop a (top) and b and push b op a,
//          any other code is ignored
//  result: one transaction per character with the new top of stack (zero when
//          empty), the depth and a status code
//  one character is worked on at a time; chars.ready is high only while the
//  sequencer is idle. states after acceptance: digit or ignored or error: decode, done;
//    add or subtract: decode, exec, write, done; multiply: decode, exec, mul, write, done;
//    divide: decode, exec, div, divfin, write, done, one quotient bit a cycle in div
//    (Q16.16 values at FRAC_BITS 16); divide by zero takes the same states as an add
//  the result sits in an output register; a stalled receiver does not stop the
//  next character from being taken, only its own result waits in the done state
//  until the output register frees up
//  reset clears the stack pointer, the sequencer and the output valid; the
//  operand memory is not cleared and entries above the pointer are never used
`include "postfix_stack_evaluator_macros.svh"

module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	pse_char_if.sink           chars,
	pse_result_if.source       result
);
	import pse_pkg::*;

	localparam int PW    = $clog2(STACK_DEPTH + 1);  // stack pointer, holds the depth
	localparam int AW    = $clog2(STACK_DEPTH);      // memory address
	localparam int DW    = 32 + FRAC_BITS;           // dividend and quotient width
	localparam int CW    = $clog2(DW);               // divide step counter
	localparam int ALU_W = 34;                       // shared adder width

	localparam logic [DW-1:0] Q_POS_LIM = DW'(32'h7fffffff);
	localparam logic [DW-1:0] Q_NEG_LIM = DW'(32'h80000000);

	// sequencer and stack control
	state_t  state_q, state_d;
	logic [PW-1:0] sp_q;
	logic signed [31:0] top_q;    // copy of the top entry, zero when empty

	// item and working registers
	logic [7:0]         char_q;
	status_t            stat_q;
	logic signed [31:0] res_q;
	logic signed [31:0] rd_data_q;
	logic signed [63:0] prod_q;
	logic [DW-1:0]      dvd_q;    // dividend, shifts into quotient
	logic [31:0]        dvs_q;
	logic [31:0]        rem_q;
	logic [CW-1:0]      cnt_q;
	logic               neg_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] out_top_q;
	logic [4:0]         out_depth_q;
	status_t            out_status_q;

	// operand memory
	logic signed [31:0] mem [STACK_DEPTH];
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic signed [31:0] mem_wd;
	logic [AW-1:0]      mem_ra;

	// decode of the held character
	logic is_digit, is_op, is_full, is_short;
	logic [PW-1:0] sp_m1, sp_m2;
	logic signed [31:0] digit_val;
	logic in_ready, load_out;

	assign is_digit  = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
	assign is_op     = (char_q == CH_PLUS) || (char_q == CH_MINUS) ||
	                   (char_q == CH_STAR) || (char_q == CH_SLASH);
	assign is_full   = (sp_q == PW'(STACK_DEPTH));
	assign is_short  = (sp_q < PW'(2));
	assign sp_m1     = sp_q - PW'(1);
	assign sp_m2     = sp_q - PW'(2);
	assign digit_val = 32'(char_q - CH_ZERO) << FRAC_BITS;

	// shared adder: add and subtract of the operands, trial subtract of the divider
	logic [ALU_W-1:0] alu_x, alu_y, alu_sum;
	logic             alu_sub;
	logic [32:0]      rem_sh;

	assign rem_sh = {rem_q, dvd_q[DW-1]};

	always_comb begin
		alu_x   = '0;
		alu_y   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_EXEC: begin
				alu_x   = {{2{rd_data_q[31]}}, rd_data_q};
				alu_y   = {{2{top_q[31]}}, top_q};
				alu_sub = (char_q == CH_MINUS);
			end
			S_DIV: begin
				alu_x   = {1'b0, rem_sh};
				alu_y   = {2'b00, dvs_q};
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign alu_sum = alu_x + (alu_sub ? ~alu_y : alu_y) + ALU_W'(alu_sub);

	// add/subtract saturation: the 33-bit sum leaves the 32-bit range
	logic add_sat;
	logic signed [31:0] add_res;
	assign add_sat = alu_sum[32] ^ alu_sum[31];
	assign add_res = add_sat ? (alu_sum[32] ? VAL_MIN : VAL_MAX) : alu_sum[31:0];

	// product after the floor shift; in range when bits 63..31 agree
	logic signed [63:0] prod_sh;
	logic               mul_ok;
	assign prod_sh = prod_q >>> FRAC_BITS;
	assign mul_ok  = (&prod_sh[63:31]) || !(|prod_sh[63:31]);

	// operand magnitudes for the divider
	logic [31:0] abs_a, abs_b;
	assign abs_a = top_q[31] ? (~top_q + 32'd1) : top_q;
	assign abs_b = rd_data_q[31] ? (~rd_data_q + 32'd1) : rd_data_q;

	// quotient sign and saturation
	logic div_sat;
	assign div_sat = neg_q ? (dvd_q > Q_NEG_LIM) : (dvd_q > Q_POS_LIM);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (chars.valid) state_d = S_DECODE;
			S_DECODE: begin
				if (is_op && !is_short) state_d = S_EXEC;
				else                    state_d = S_DONE;
			end
			S_EXEC: begin
				priority if (char_q == CH_STAR)                     state_d = S_MUL;
				else if (char_q == CH_SLASH && top_q != 32'sd0)     state_d = S_DIV;
				else                                                state_d = S_WRITE;
			end
			S_MUL:    state_d = S_WRITE;
			S_DIV:    if (cnt_q == '0) state_d = S_DIVFIN;
			S_DIVFIN: state_d = S_WRITE;
			S_WRITE:  state_d = S_DONE;
			S_DONE:   if (!out_valid_q || result.ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		load_out = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = sp_q[AW-1:0];
		mem_wd   = digit_val;
		mem_ra   = sp_m2[AW-1:0];
		unique case (state_q)
			S_IDLE:   in_ready = 1'b1;
			S_DECODE: mem_we = is_digit && !is_full;
			S_WRITE: begin
				mem_we = 1'b1;
				mem_wa = sp_m2[AW-1:0];
				mem_wd = res_q;
			end
			S_DONE:   load_out = !out_valid_q || result.ready;
			default: begin
			end
		endcase
	end

	assign chars.ready = in_ready;

	// operand memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[mem_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (chars.valid && chars.start_req) begin
						sp_q  <= '0;
						top_q <= '0;
					end
				end
				S_DECODE: begin
					if (is_digit && !is_full) begin
						sp_q  <= sp_q + PW'(1);
						top_q <= digit_val;
					end
				end
				S_WRITE: begin
					sp_q  <= sp_m1;
					top_q <= res_q;
				end
				default: begin
				end
			endcase
			if (load_out)          out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (chars.valid) char_q <= chars.char_code;
			S_DECODE: begin
				priority if (is_digit) stat_q <= is_full ? STAT_FULL : STAT_OK;
				else if (is_op)        stat_q <= is_short ? STAT_UNDERFLOW : STAT_OK;
				else                   stat_q <= STAT_IGNORED;
			end
			S_EXEC: begin
				priority if (char_q == CH_STAR) begin
					prod_q <= rd_data_q * top_q;
				end else if (char_q == CH_SLASH) begin
					if (top_q == 32'sd0) begin
						// divide by zero saturates toward the sign of b
						res_q  <= rd_data_q[31] ? VAL_MIN : VAL_MAX;
						stat_q <= STAT_DIVZERO;
					end else begin
						dvd_q <= DW'(abs_b) << FRAC_BITS;
						dvs_q <= abs_a;
						rem_q <= '0;
						cnt_q <= CW'(DW - 1);
						neg_q <= rd_data_q[31] ^ top_q[31];
					end
				end else begin
					res_q  <= add_res;
					stat_q <= add_sat ? STAT_SAT : STAT_OK;
				end
			end
			S_MUL: begin
				if (mul_ok) begin
					res_q <= prod_sh[31:0];
				end else begin
					res_q  <= prod_sh[63] ? VAL_MIN : VAL_MAX;
					stat_q <= STAT_SAT;
				end
			end
			S_DIV: begin
				// restoring step: keep the difference when it did not go negative
				if (!alu_sum[ALU_W-1]) rem_q <= alu_sum[31:0];
				else                   rem_q <= rem_sh[31:0];
				dvd_q <= {dvd_q[DW-2:0], !alu_sum[ALU_W-1]};
				cnt_q <= cnt_q - CW'(1);
			end
			S_DIVFIN: begin
				if (div_sat) begin
					res_q  <= neg_q ? VAL_MIN : VAL_MAX;
					stat_q <= STAT_SAT;
				end else begin
					res_q <= neg_q ? (~dvd_q[31:0] + 32'd1) : dvd_q[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_top_q    <= (sp_q == '0) ? 32'sd0 : top_q;
			out_depth_q  <= 5'(sp_q);
			out_status_q <= stat_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.top_value   = out_top_q;
	assign result.stack_depth = out_depth_q;
	assign result.status      = out_status_q;

	// checks
	`PSE_ASSERT_ALWAYS(a_sp_bound, clk, arst_n, sp_q <= PW'(STACK_DEPTH), "stack pointer past depth")
	`PSE_ASSERT_IMPLY(a_exec_two, clk, arst_n, state_q == S_EXEC, sp_q >= PW'(2), "operator run with fewer than two operands")
	`PSE_ASSERT_IMPLY(a_div_nonzero, clk, arst_n, state_q == S_DIV, dvs_q != 32'd0, "divider running on a zero divisor")
	`PSE_ASSERT_NEXT(a_write_pop, clk, arst_n, state_q == S_WRITE, sp_q == $past(sp_m1), "write back did not pop one operand")

endmodule

>>> tb/tb.sv
// testbench for postfix_stack_evaluator: directed table then random character streams
// scoreboards every result against its typed row or an in-bench stack predictor; needs pse_pkg and pse_if
`timescale 1ns / 100ps

module tb;
	import pse_pkg::*;

	localparam int STACK_SIZE    = 16;
	localparam int FRAC          = 16;
	localparam int NUM_DIRECTED  = 25;
	localparam int NUM_RANDOM    = 1400;
	localparam int STALL_LIMIT   = 5000;
	localparam int DRAIN_CYCLES  = 120;
	localparam int HOLD_OFF      = 500;

	typedef struct {
		logic signed [31:0] top;
		logic [4:0]         depth;
		status_t            status;
	} result_t;

	// one directed row; typed rows carry their expected result, others use the predictor
	typedef struct {
		logic [7:0]         ch;
		logic               start;
		bit                 typed;
		logic signed [31:0] top;
		logic [4:0]         depth;
		status_t            status;
	} step_t;

	logic clk;
	logic arst_n;

	pse_char_if   chars_if ();
	pse_result_if res_if ();

	postfix_stack_evaluator #(
		.STACK_DEPTH(STACK_SIZE),
		.FRAC_BITS  (FRAC)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.chars (chars_if),
		.result(res_if)
	);

	// predictor state: operand stack and its fill level
	logic signed [31:0] stack_vals [STACK_SIZE];
	int                 stack_len;

	result_t expected_q [$];
	int      mismatches;
	int      results_checked;
	int      burst_left;

	// directed rows: error codes, extremes, every operator, both divide-by-zero signs,
	// multiply chain into saturation, add on a saturated value
	step_t directed_steps [NUM_DIRECTED] = '{
		'{CH_PLUS,        1'b1, 1'b1, 32'sd0,       5'd0, STAT_UNDERFLOW},
		'{8'h00,          1'b0, 1'b1, 32'sd0,       5'd0, STAT_IGNORED},
		'{8'hff,          1'b0, 1'b1, 32'sd0,       5'd0, STAT_IGNORED},
		'{CH_NINE,        1'b1, 1'b1, 32'sh00090000, 5'd1, STAT_OK},
		'{CH_MINUS,       1'b0, 1'b1, 32'sh00090000, 5'd1, STAT_UNDERFLOW},
		'{CH_ZERO,        1'b0, 1'b1, 32'sd0,       5'd2, STAT_OK},
		'{CH_SLASH,       1'b0, 1'b1, VAL_MAX,      5'd1, STAT_DIVZERO},
		'{CH_ZERO,        1'b1, 1'b1, 32'sd0,       5'd1, STAT_OK},
		'{CH_ZERO + 8'd7, 1'b0, 1'b0, 32'sd0,       5'd0, STAT_OK},
		'{CH_MINUS,       1'b0, 1'b0, 32'sd0,       5'd0, STAT_OK},
		'{CH_ZERO,        1'b0, 1'b0, 32'sd0,       5'd0, STAT_OK},
		'{CH_SLASH,       1'b0, 1'b1, VAL_MIN,      5'd1, STAT_DIVZERO},
		'{CH_NINE,        1'b1, 1'b0, 32'sd0,       5'd0, STAT_OK},
		'{CH_NINE,        1'b0, 1'b0, 32'sd0,       5'd0, STAT_OK},
		'{CH_STAR,        1'b0, 1'b0, 32'sd0,       5'd0, STAT_OK},
		'{CH_NINE,        1'b0, 1'b0, 32'sd0,       5'd0, STAT_OK},
		'{CH_STAR,        1'b0, 1'b0, 32'sd0,       5'd0, STAT_OK},
		'{CH_NINE,        1'b0, 1'b0, 32'sd0,       5'd0, STAT_OK},
		'{CH_STAR,        1'b0, 1'b0, 32'sd0,       5'd0, STAT_OK},
		'{CH_NINE,        1'b0, 1'b0, 32'sd0,       5'd0, STAT_OK},
		'{CH_STAR,        1'b0, 1'b1, VAL_MAX,      5'd1, STAT_SAT},
		'{CH_ZERO + 8'd3, 1'b0, 1'b0, 32'sd0,       5'd0, STAT_OK},
		'{CH_PLUS,        1'b0, 1'b1, VAL_MAX,      5'd1, STAT_SAT},
		'{CH_ZERO + 8'd2, 1'b0, 1'b0, 32'sd0,       5'd0, STAT_OK},
		'{CH_SLASH,       1'b0, 1'b0, 32'sd0,       5'd0, STAT_OK}
	};

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// evaluate one character on the predictor stack and return the new top, depth, status
	function automatic result_t eval_char(input logic [7:0] c, input logic s);
		result_t r;
		longint  a;
		longint  b;
		longint  v;
		bit      sat;
		r.status = STAT_OK;
		sat = 1'b0;
		if (s)
			stack_len = 0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (stack_len >= STACK_SIZE) begin
				r.status = STAT_FULL;
			end else begin
				stack_vals[stack_len] = 32'(longint'(c - CH_ZERO) <<< FRAC);
				stack_len++;
			end
		end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
			if (stack_len < 2) begin
				r.status = STAT_UNDERFLOW;
			end else begin
				a = stack_vals[stack_len - 1];
				b = stack_vals[stack_len - 2];
				case (c)
					CH_PLUS:  v = b + a;
					CH_MINUS: v = b - a;
					// arithmetic shift of the exact product rounds toward minus infinity
					CH_STAR:  v = (b * a) >>> FRAC;
					default: begin
						if (a == 0) begin
							v = (b >= 0) ? longint'(VAL_MAX) : longint'(VAL_MIN);
							r.status = STAT_DIVZERO;
						end else begin
							// signed division truncates toward zero
							v = (b <<< FRAC) / a;
						end
					end
				endcase
				if (v > longint'(VAL_MAX)) begin
					v = VAL_MAX;
					sat = 1'b1;
				end else if (v < longint'(VAL_MIN)) begin
					v = VAL_MIN;
					sat = 1'b1;
				end
				if (sat)
					r.status = STAT_SAT;
				stack_len--;
				stack_vals[stack_len - 1] = v[31:0];
			end
		end else begin
			r.status = STAT_IGNORED;
		end
		r.top   = (stack_len > 0) ? stack_vals[stack_len - 1] : 32'sd0;
		r.depth = 5'(stack_len);
		return r;
	endfunction

	// offer one character until accepted, record its expected result, then maybe idle
	task automatic send_char(input logic [7:0] c, input logic s, input bit typed,
		input result_t typed_res);
		result_t pred;
		int      gap;
		int      r;
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= c;
		chars_if.start_req <= s;
		do
			@(posedge clk);
		while (!chars_if.ready);
		// predictor always advances so later rows stay in step
		pred = eval_char(c, s);
		expected_q.push_back(typed ? typed_res : pred);
		// gap after the transaction: mostly short, a few long, bursts with none
		r = $urandom_range(0, 99);
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if (r < 2) begin
			burst_left = $urandom_range(20, 60);
			gap = 0;
		end else if (r < 50) begin
			gap = 0;
		end else if (r < 88) begin
			gap = $urandom_range(1, 3);
		end else if (r < 97) begin
			gap = $urandom_range(4, 10);
		end else begin
			gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stimulus
	initial begin : stimulus
		result_t    typed_res;
		logic [7:0] c;
		logic       s;
		int         r;
		int         counted;
		int         fill_left;
		int         gen_depth;
		bit         is_digit;
		bit         is_op;
		arst_n             = 1'b0;
		chars_if.valid     <= 1'b0;
		chars_if.char_code <= 8'h00;
		chars_if.start_req <= 1'b0;
		stack_len  = 0;
		mismatches = 0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_steps[i]) begin
			typed_res.top    = directed_steps[i].top;
			typed_res.depth  = directed_steps[i].depth;
			typed_res.status = directed_steps[i].status;
			send_char(directed_steps[i].ch, directed_steps[i].start,
				directed_steps[i].typed, typed_res);
		end

		// random streams: mostly well-formed expressions with random digits, runs of
		// pushes that overfill the stack, start requests, and some noise characters
		counted   = 0;
		fill_left = 0;
		gen_depth = 1;
		typed_res = '{top: 32'sd0, depth: 5'd0, status: STAT_OK};
		while (counted < NUM_RANDOM) begin
			r = $urandom_range(0, 99);
			s = 1'b0;
			if (fill_left > 0) begin
				fill_left--;
				c = CH_ZERO + 8'($urandom_range(0, 9));
			end else if (r < 3) begin
				fill_left = $urandom_range(14, 20);
				c = CH_ZERO + 8'($urandom_range(0, 9));
			end else if (r < 7) begin
				s = 1'b1;
				c = $urandom_range(0, 1) ? CH_ZERO + 8'($urandom_range(0, 9)) : CH_PLUS;
			end else if (r < 15) begin
				c = 8'($urandom_range(0, 255));
			end else if (r < 55 || (gen_depth < 2 && r < 95)) begin
				c = CH_ZERO + 8'($urandom_range(0, 9));
			end else begin
				case ($urandom_range(0, 3))
					0: c = CH_PLUS;
					1: c = CH_MINUS;
					2: c = CH_STAR;
					default: c = CH_SLASH;
				endcase
			end
			is_digit = (c >= CH_ZERO && c <= CH_NINE);
			is_op    = (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH);
			// generator-side depth, independent of operand values
			if (s)
				gen_depth = 0;
			if (is_digit && gen_depth < STACK_SIZE)
				gen_depth++;
			else if (is_op && gen_depth >= 2)
				gen_depth--;
			// every character sent counts, noise included
			counted++;
			send_char(c, s, 1'b0, typed_res);
		end
		chars_if.valid <= 1'b0;

		while (expected_q.size() != 0)
			@(posedge clk);
		// leave room for a stray late result
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// receiver ready: random spans, plus one long hold-off that backs up the block
	initial begin : receiver
		int  r;
		int  span;
		bit  held;
		res_if.ready <= 1'b0;
		held = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (!held && results_checked >= 300) begin
				held = 1'b1;
				res_if.ready <= 1'b0;
				span = HOLD_OFF;
			end else if (r < 60) begin
				res_if.ready <= 1'b1;
				span = $urandom_range(1, 40);
			end else if (r < 95) begin
				res_if.ready <= 1'b0;
				span = $urandom_range(1, 4);
			end else begin
				res_if.ready <= 1'b0;
				span = $urandom_range(20, 60);
			end
			repeat (span) @(posedge clk);
		end
	end

	// compare each result transaction with the oldest expectation
	initial results_checked = 0;

	always @(posedge clk) begin : result_check
		result_t e;
		if (res_if.valid && res_if.ready) begin
			results_checked++;
			if (expected_q.size() == 0) begin
				$error("result transaction with no expectation pending");
				mismatches++;
			end else begin
				e = expected_q.pop_front();
				if (res_if.top_value !== e.top) begin
					$error("top_value: expected %0d, actual %0d", e.top, res_if.top_value);
					mismatches++;
				end
				if (res_if.stack_depth !== e.depth) begin
					$error("stack_depth: expected %0d, actual %0d", e.depth,
						res_if.stack_depth);
					mismatches++;
				end
				if (res_if.status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, res_if.status);
					mismatches++;
				end
			end
		end
	end

	// watchdog: too many cycles with no transaction on either channel
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready))
				idle = 0;
			else
				idle++;
		end
		$display("tb: FAIL");
		$finish;
	end

endmodule

>>> postfix_stack_evaluator.f
+incdir+hw/rtl
hw/rtl/pse_pkg.sv
hw/rtl/pse_if.sv
hw/rtl/postfix_stack_evaluator.sv
tb/tb.sv
